@@ design/mcmp_pkg.sv @@
`default_nettype none

package mcmp_pkg;

	typedef enum logic [1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_OFF = 2'd1,
		KIND_CC       = 2'd2
	} msg_kind_t;

	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_CC       = 4'hB;
	localparam logic [3:0] CMD_PROGRAM  = 4'hC;
	localparam logic [3:0] CMD_PRESSURE = 4'hD;
	localparam logic [3:0] CMD_SYSTEM   = 4'hF;

	typedef struct packed {
		logic [7:0] status;
		logic       have_first;
		logic [6:0] first_data;
	} parse_state_t;

	typedef struct packed {
		logic       valid;
		msg_kind_t  kind;
		logic [3:0] channel;
		logic [6:0] key;
		logic [6:0] amount;
	} parse_result_t;

endpackage

`default_nettype wire

@@ design/mcmp_decode.sv @@
`default_nettype none

module mcmp_decode
	import mcmp_pkg::*;
(
	input  logic [7:0]    midi_byte,
	input  parse_state_t  cur,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic [3:0] cmd;
	logic       one_byte;

	assign cmd = cur.status[7:4];

	always_comb begin
		unique case (cmd)
			CMD_PROGRAM, CMD_PRESSURE: one_byte = 1'b1;
			default:                   one_byte = 1'b0;
		endcase
	end

	always_comb begin
		nxt         = cur;
		res.valid   = 1'b0;
		res.kind    = KIND_NOTE_ON;
		res.channel = cur.status[3:0];
		res.key     = cur.first_data;
		res.amount  = midi_byte[6:0];

		if (midi_byte[7]) begin
			if (midi_byte[7:4] == CMD_SYSTEM) begin
				// System common clears running status; real-time is ignored.
				if (!midi_byte[3]) begin
					nxt.status     = 8'h00;
					nxt.have_first = 1'b0;
				end
			end else begin
				nxt.status     = midi_byte;
				nxt.have_first = 1'b0;
			end
		end else if (cur.status != 8'h00) begin
			if (!one_byte && !cur.have_first) begin
				nxt.first_data = midi_byte[6:0];
				nxt.have_first = 1'b1;
			end else begin
				nxt.have_first = 1'b0;
				unique case (cmd)
					CMD_NOTE_ON: begin
						res.valid = 1'b1;
						res.kind  = (midi_byte[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
					end
					CMD_NOTE_OFF: begin
						res.valid = 1'b1;
						res.kind  = KIND_NOTE_OFF;
					end
					CMD_CC: begin
						res.valid = 1'b1;
						res.kind  = KIND_CC;
					end
					default: res.valid = 1'b0;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

@@ design/midi_channel_message_parser_top.sv @@
// Parses a raw serial MIDI byte stream with running status and reports note on,
// note off and control change messages. One byte is taken per transfer and a
// byte can be taken in every cycle unless a result waits on out_ready; the last
// data byte of a message goes through the input register, then the result
// register. Real-time bytes are ignored, system common bytes cancel the running
// status, and a note on with zero velocity is reported as a note off.
`default_nettype none

module midi_channel_message_parser_top
	import mcmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] midi_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] msg_kind,
	output logic [3:0] channel,
	output logic [6:0] key,
	output logic [6:0] amount
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic [7:0]    status_q;
	logic          have_first_q;
	logic [6:0]    first_data_q;
	logic          out_valid_q;
	msg_kind_t     kind_q;
	logic [3:0]    channel_q;
	logic [6:0]    key_q;
	logic [6:0]    amount_q;
	logic          advance;
	parse_state_t  cur;
	parse_state_t  nxt;
	parse_result_t res;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cur.status     = status_q;
	assign cur.have_first = have_first_q;
	assign cur.first_data = first_data_q;

	mcmp_decode u_decode (
		.midi_byte (byte_s1),
		.cur       (cur),
		.nxt       (nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			status_q     <= 8'h00;
			have_first_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				status_q     <= nxt.status;
				have_first_q <= nxt.have_first;
				out_valid_q  <= res.valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= midi_byte;
		end
		if (advance) begin
			first_data_q <= nxt.first_data;
		end
		if (advance && res.valid) begin
			kind_q    <= res.kind;
			channel_q <= res.channel;
			key_q     <= res.key;
			amount_q  <= res.amount;
		end
	end

	assign out_valid = out_valid_q;
	assign msg_kind  = kind_q;
	assign channel   = channel_q;
	assign key       = key_q;
	assign amount    = amount_q;

	a_status_is_channel: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != 8'h00 |-> status_q[7] && status_q[7:4] != CMD_SYSTEM)
		else $error("Running status holds a byte that is not a channel status.");

	a_first_needs_status: assert property (@(posedge clk) disable iff (!arst_n)
		have_first_q |-> status_q != 8'h00)
		else $error("First data byte held without running status.");

	a_realtime_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1[7:3] == 5'b11111 |=> $stable(status_q) && $stable(have_first_q))
		else $error("Real-time byte disturbed the parser state.");

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> kind_q == KIND_NOTE_ON || kind_q == KIND_NOTE_OFF || kind_q == KIND_CC)
		else $error("Result carries an unknown message kind.");

endmodule

`default_nettype wire
